[src/eam_pkg.sv]
// eam_pkg: shared types, polynomial coefficients and the q30 product helper
// used by the trig and matrix stages of euler_angles_to_rotation_matrix
// no dependencies
`default_nettype none

package eam_pkg;

    typedef logic signed [31:0] t_q30;

    localparam int NumEntries = 9;
    localparam int NumCoef    = 6;
    localparam int OutWidth   = 16;

    // odd sine polynomial over a quarter wave in q30: c1, c3, c5, c7, c9, c11
    localparam logic [31:0] PolyCoef [NumCoef] = '{
        32'd1686629713, 32'd693598668, 32'd85569310,
        32'd5026996,    32'd172272,    32'd3864
    };

    // q30 product, magnitude rounded half away from zero
    function automatic t_q30 mulq(input t_q30 a, input t_q30 b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] prod;
        logic [31:0] p;
        ma   = a[31] ? 32'(-a) : 32'(a);
        mb   = b[31] ? 32'(-b) : 32'(b);
        prod = 64'(ma) * 64'(mb) + (64'd1 << 29);
        p    = prod[61:30];
        return (a[31] != b[31]) ? t_q30'(-p) : t_q30'(p);
    endfunction

endpackage

`default_nettype wire

[src/euler_angles_to_rotation_matrix.sv]
// euler_angles_to_rotation_matrix: top level, stream ports, valid pipeline
// depends on eam_pkg, eam_trig and eam_mix
`default_nettype none

// Turns three binary angles (a full turn is 2^ANGLE_BITS units) into the nine
// entries of a 3x3 rotation matrix in signed Q1.FRAC_BITS, rounded half away
// from zero and saturated to plus or minus one. The cfg register picks the
// convention: 0 gives the XYZ euler matrix, 1 the ZXY axes matrix; it resets
// to 0 and is sampled along with each transaction. The datapath is a 12-stage
// pipeline: one stage folds the angle to a quadrant, one squares the phase,
// five run the horner steps of the sine polynomial, one forms the last
// product, clamp and sign (six sine/cosine units in parallel), then first
// products, three-factor products, sums and output rounding. A new
// transaction is taken every cycle unless the master side stalls. The whole
// pipeline advances together, so back-pressure on the master side holds
// every stage and drops s_axis_tready only when the output register is
// full and not taken.
module euler_angles_to_rotation_matrix #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // configuration
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic          i_cfg_data,     // angle_order
    // slave side
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [47:0]   s_axis_tdata,   // angle_x, angle_y, angle_z
    // master side
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [143:0]       m_axis_tdata    // m00 m01 m02 m10 m11 m12 m20 m21 m22
);
    import eam_pkg::*;

    localparam int TrigLat = 8;
    localparam int Lat     = TrigLat + 4;

    logic           r_order;
    logic [Lat-1:0] r_vld;
    logic [TrigLat-1:0] r_ord;
    logic           adv;

    // pipeline advances when the output stage is empty or being taken
    assign adv           = !r_vld[Lat-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_vld[Lat-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
            r_vld   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_order <= i_cfg_data;
            end
            if (adv) begin
                r_vld <= {r_vld[Lat-2:0], s_axis_tvalid};
            end
        end
    end

    // convention bit travels alongside the trig stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ord <= {r_ord[TrigLat-2:0], r_order};
        end
    end

    // angles: only the low ANGLE_BITS of each field count
    logic [ANGLE_BITS-1:0] ang [3];
    t_q30 sinv [3];
    t_q30 cosv [3];

    for (genvar g = 0; g < 3; g++) begin : g_axis
        assign ang[g] = ANGLE_BITS'(s_axis_tdata[g*16 +: 16]);
        eam_trig #(.ANGLE_BITS(ANGLE_BITS), .IS_COS(1'b0)) u_sin (
            .i_clk   (i_clk),
            .i_en    (adv),
            .i_angle (ang[g]),
            .o_val   (sinv[g])
        );
        eam_trig #(.ANGLE_BITS(ANGLE_BITS), .IS_COS(1'b1)) u_cos (
            .i_clk   (i_clk),
            .i_en    (adv),
            .i_angle (ang[g]),
            .o_val   (cosv[g])
        );
    end

    eam_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_order (r_ord[TrigLat-1]),
        .i_sx    (sinv[0]),
        .i_cx    (cosv[0]),
        .i_sy    (sinv[1]),
        .i_cy    (cosv[1]),
        .i_sz    (sinv[2]),
        .i_cz    (cosv[2]),
        .o_mat   (m_axis_tdata)
    );

`ifndef SYNTH
    // output valid only appears one stage after the previous stage held an item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_vld[Lat-2]))
        else $error("output valid without a preceding stage");

    // a stall freezes every valid bit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("valid pipeline moved during stall");

    // m00 stays within plus or minus one at the default format
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (FRAC_BITS != 14) ||
        ($signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
         $signed(m_axis_tdata[15:0]) >= -16'sd16384))
        else $error("m00 out of range");
`endif

endmodule

`default_nettype wire

[src/eam_trig.sv]
// eam_trig: eight-stage pipelined sine or cosine of one binary angle, q30 out
// depends on eam_pkg
`default_nettype none

module eam_trig #(
    parameter int ANGLE_BITS = 16,
    parameter bit IS_COS     = 1'b0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [ANGLE_BITS-1:0] i_angle,
    output eam_pkg::t_q30              o_val
);
    import eam_pkg::*;

    localparam int HornerSteps = NumCoef - 1;
    localparam logic [ANGLE_BITS-1:0] Quarter = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-2:0] QLen    = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);

    logic [ANGLE_BITS-1:0] phase;
    logic [ANGLE_BITS-2:0] p;
    logic [30:0]           n_t;
    logic [61:0]           sq;

    logic [30:0] r_t1;
    logic        r_neg1;
    logic [30:0] r_u2;
    logic [30:0] r_t2;
    logic        r_neg2;
    logic [31:0] r_h   [HornerSteps];
    logic [30:0] r_uh  [HornerSteps];
    logic [30:0] r_th  [HornerSteps];
    logic        r_nh  [HornerSteps];
    t_q30        r_out;

    // fold the phase into the first quadrant
    always_comb begin
        phase = IS_COS ? ANGLE_BITS'(i_angle + Quarter) : i_angle;
        p     = {1'b0, phase[ANGLE_BITS-3:0]};
        if (phase[ANGLE_BITS-2]) begin
            p = QLen - p;
        end
        n_t = 31'(p) << (32 - ANGLE_BITS);
        sq  = 62'(r_t1) * 62'(r_t1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1   <= n_t;
            r_neg1 <= phase[ANGLE_BITS-1];
            r_u2   <= sq[60:30];
            r_t2   <= r_t1;
            r_neg2 <= r_neg1;
        end
    end

    for (genvar g = 0; g < HornerSteps; g++) begin : g_horner
        logic [31:0] prev_r;
        logic [30:0] prev_u;
        logic [30:0] prev_t;
        logic        prev_n;
        logic [62:0] prod;
        if (g == 0) begin : g_first
            assign prev_r = PolyCoef[NumCoef-1];
            assign prev_u = r_u2;
            assign prev_t = r_t2;
            assign prev_n = r_neg2;
        end else begin : g_next
            assign prev_r = r_h[g-1];
            assign prev_u = r_uh[g-1];
            assign prev_t = r_th[g-1];
            assign prev_n = r_nh[g-1];
        end
        assign prod = 63'(prev_u) * 63'(prev_r);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_h[g]  <= PolyCoef[HornerSteps-1-g] - prod[61:30];
                r_uh[g] <= prev_u;
                r_th[g] <= prev_t;
                r_nh[g] <= prev_n;
            end
        end
    end

    logic [62:0] fin;
    logic [31:0] mag;
    always_comb begin
        fin = 63'(r_th[HornerSteps-1]) * 63'(r_h[HornerSteps-1]);
        mag = fin[61:30];
        if (mag > 32'h4000_0000) begin
            mag = 32'h4000_0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_nh[HornerSteps-1] ? t_q30'(-mag) : t_q30'(mag);
        end
    end

    assign o_val = r_out;

endmodule

`default_nettype wire

[src/eam_mix.sv]
// eam_mix: four-stage product, sum and q30 to output conversion of the matrix
// depends on eam_pkg
`default_nettype none

module eam_mix #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic          i_order,
    input  eam_pkg::t_q30      i_sx,
    input  eam_pkg::t_q30      i_cx,
    input  eam_pkg::t_q30      i_sy,
    input  eam_pkg::t_q30      i_cy,
    input  eam_pkg::t_q30      i_sz,
    input  eam_pkg::t_q30      i_cz,
    output logic [eam_pkg::NumEntries*eam_pkg::OutWidth-1:0] o_mat
);
    import eam_pkg::*;

    localparam int Sh = 30 - FRAC_BITS;
    localparam logic [33:0] Lim = 34'(1) << FRAC_BITS;

    // stage a: first products
    t_q30 r_cycz, r_cysz, r_sxsy, r_cxsz, r_cxcz, r_sxcy;
    t_q30 r_cxsy, r_sxsz, r_sxcz, r_cxcy, r_czsy, r_szsy;
    t_q30 r_sxa, r_sya, r_cya, r_cza, r_sza;
    logic r_orda;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cycz <= mulq(i_cy, i_cz);
            r_cysz <= mulq(i_cy, i_sz);
            r_sxsy <= mulq(i_sx, i_sy);
            r_cxsz <= mulq(i_cx, i_sz);
            r_cxcz <= mulq(i_cx, i_cz);
            r_sxcy <= mulq(i_sx, i_cy);
            r_cxsy <= mulq(i_cx, i_sy);
            r_sxsz <= mulq(i_sx, i_sz);
            r_sxcz <= mulq(i_sx, i_cz);
            r_cxcy <= mulq(i_cx, i_cy);
            r_czsy <= mulq(i_cz, i_sy);
            r_szsy <= mulq(i_sz, i_sy);
            r_sxa  <= i_sx;
            r_sya  <= i_sy;
            r_cya  <= i_cy;
            r_cza  <= i_cz;
            r_sza  <= i_sz;
            r_orda <= i_order;
        end
    end

    // stage b: three-factor products, operands picked by convention
    t_q30 r_q0, r_q1, r_q2, r_q3;
    t_q30 r_cyczb, r_cyszb, r_cxszb, r_cxczb, r_sxcyb, r_cxsyb;
    t_q30 r_sxszb, r_sxczb, r_cxcyb, r_czsyb, r_szsyb, r_sxb, r_syb;
    logic r_ordb;
    t_q30 f0, f1, g0, g1;

    always_comb begin
        f0 = r_orda ? r_sxsz : r_sxsy;
        f1 = r_orda ? r_sxcz : r_cxsy;
        g0 = r_orda ? r_sya  : r_cza;
        g1 = r_orda ? r_cya  : r_sza;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0    <= mulq(f0, g0);
            r_q1    <= mulq(f0, g1);
            r_q2    <= mulq(f1, g0);
            r_q3    <= mulq(f1, g1);
            r_cyczb <= r_cycz;
            r_cyszb <= r_cysz;
            r_cxszb <= r_cxsz;
            r_cxczb <= r_cxcz;
            r_sxcyb <= r_sxcy;
            r_cxsyb <= r_cxsy;
            r_sxszb <= r_sxsz;
            r_sxczb <= r_sxcz;
            r_cxcyb <= r_cxcy;
            r_czsyb <= r_czsy;
            r_szsyb <= r_szsy;
            r_sxb   <= r_sxa;
            r_syb   <= r_sya;
            r_ordb  <= r_orda;
        end
    end

    // stage c: sums
    logic signed [33:0] n_sum [NumEntries];
    logic signed [33:0] r_sum [NumEntries];

    function automatic logic signed [33:0] ext(input t_q30 v);
        return 34'(v);
    endfunction

    always_comb begin
        if (r_ordb) begin
            n_sum[0] = ext(r_cyczb) + ext(r_q0);
            n_sum[1] = ext(r_cxszb);
            n_sum[2] = ext(r_q1) - ext(r_czsyb);
            n_sum[3] = ext(r_q2) - ext(r_cyszb);
            n_sum[4] = ext(r_cxczb);
            n_sum[5] = ext(r_szsyb) + ext(r_q3);
            n_sum[6] = ext(r_cxsyb);
            n_sum[7] = -ext(r_sxb);
            n_sum[8] = ext(r_cxcyb);
        end else begin
            n_sum[0] = ext(r_cyczb);
            n_sum[1] = ext(r_cyszb);
            n_sum[2] = -ext(r_syb);
            n_sum[3] = ext(r_q0) - ext(r_cxszb);
            n_sum[4] = ext(r_q1) + ext(r_cxczb);
            n_sum[5] = ext(r_sxcyb);
            n_sum[6] = ext(r_q2) + ext(r_sxszb);
            n_sum[7] = ext(r_q3) - ext(r_sxczb);
            n_sum[8] = ext(r_cxcyb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    // stage d: round half away from zero, saturate, keep low bits
    logic [OutWidth-1:0] r_out [NumEntries];

    for (genvar g = 0; g < NumEntries; g++) begin : g_conv
        logic [33:0] mag;
        logic [33:0] rnd;
        logic [33:0] sat;
        assign mag = r_sum[g][33] ? 34'(-r_sum[g]) : 34'(r_sum[g]);
        if (Sh > 0) begin : g_round
            assign rnd = (mag + (34'(1) << (Sh - 1))) >> Sh;
        end else begin : g_exact
            assign rnd = mag;
        end
        assign sat = (rnd > Lim) ? Lim : rnd;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_out[g] <= r_sum[g][33] ? OutWidth'(-sat) : OutWidth'(sat);
            end
        end
        assign o_mat[g*OutWidth +: OutWidth] = r_out[g];
    end

endmodule

`default_nettype wire

[dv/euler_angles_to_rotation_matrix_tb.sv]
// euler_angles_to_rotation_matrix_tb: self-checking bench for the rotation matrix block
// drives angle triples on the stream input, checks the nine q1.14 entries against a local model
// depends on the block itself
`timescale 1ns / 1ps

module euler_angles_to_rotation_matrix_tb;

    typedef logic signed [63:0] t_wide;

    // one matrix of nine 16-bit entries, packed m00 in the lowest bits
    typedef logic [143:0] t_matrix;

    // convention codes for the order register
    localparam logic ORDER_XYZ = 1'b0;
    localparam logic ORDER_ZXY = 1'b1;

    localparam logic [63:0] SINE_COEF [6] = '{
        64'd1686629713, 64'd693598668, 64'd85569310,
        64'd5026996, 64'd172272, 64'd3864
    };

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic           i_cfg_data;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [47:0]    s_axis_tdata;     // angle_x, angle_y, angle_z
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [143:0]   m_axis_tdata;     // m00 m01 m02 m10 m11 m12 m20 m21 m22

    euler_angles_to_rotation_matrix u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // model copy of the order register
    logic     model_order;
    t_matrix  pending_matrices [$];
    int       fail_count;
    bit       sink_idle_on;

    // quarter-wave sine polynomial, q30, truncating at every step
    function automatic t_wide quarter_sine(input logic [63:0] t);
        logic [63:0] u;
        logic [63:0] r;
        u = (t * t) >> 30;
        r = SINE_COEF[5];
        for (int k = 4; k >= 0; k--) r = SINE_COEF[k] - ((u * r) >> 30);
        r = (t * r) >> 30;
        if (r > 64'd1073741824) r = 64'd1073741824;
        return t_wide'(r);
    endfunction

    function automatic t_wide sine_of(input logic [15:0] a);
        logic [1:0]  quad;
        logic [63:0] p;
        t_wide       s;
        quad = a[15:14];
        p    = {50'd0, a[13:0]};
        if (quad[0]) p = 64'd16384 - p;
        s = quarter_sine(p << 16);
        return quad[1] ? -s : s;
    endfunction

    function automatic t_wide cosine_of(input logic [15:0] a);
        return sine_of(a + 16'd16384);
    endfunction

    function automatic t_wide qmul(input t_wide a, input t_wide b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] p;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p  = (ma * mb + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -t_wide'(p) : t_wide'(p);
    endfunction

    // round q30 to q14 half away from zero, saturate to one
    function automatic logic [15:0] to_q14(input t_wide v);
        logic [63:0] m;
        m = v < 0 ? -v : v;
        m = (m + 64'd32768) >> 16;
        if (m > 64'd16384) m = 64'd16384;
        if (v < 0) m = -m;
        return m[15:0];
    endfunction

    function automatic t_matrix rotation_of(input logic [47:0] angles, input logic order);
        t_wide   sx, cx, sy, cy, sz, cz;
        t_wide   e [9];
        t_matrix r;
        sx = sine_of(angles[15:0]);
        cx = cosine_of(angles[15:0]);
        sy = sine_of(angles[31:16]);
        cy = cosine_of(angles[31:16]);
        sz = sine_of(angles[47:32]);
        cz = cosine_of(angles[47:32]);
        if (order == ORDER_XYZ) begin
            e[0] = qmul(cy, cz);
            e[1] = qmul(cy, sz);
            e[2] = -sy;
            e[3] = qmul(qmul(sx, sy), cz) - qmul(cx, sz);
            e[4] = qmul(qmul(sx, sy), sz) + qmul(cx, cz);
            e[5] = qmul(sx, cy);
            e[6] = qmul(qmul(cx, sy), cz) + qmul(sx, sz);
            e[7] = qmul(qmul(cx, sy), sz) - qmul(sx, cz);
            e[8] = qmul(cx, cy);
        end else begin
            e[0] = qmul(cz, cy) + qmul(qmul(sz, sx), sy);
            e[1] = qmul(sz, cx);
            e[2] = -qmul(cz, sy) + qmul(qmul(sz, sx), cy);
            e[3] = -qmul(sz, cy) + qmul(qmul(cz, sx), sy);
            e[4] = qmul(cz, cx);
            e[5] = qmul(sz, sy) + qmul(qmul(cz, sx), cy);
            e[6] = qmul(cx, sy);
            e[7] = -sx;
            e[8] = qmul(cx, cy);
        end
        for (int k = 0; k < 9; k++) r[k*16 +: 16] = to_q14(e[k]);
        return r;
    endfunction

    // directed rows: angles, convention, typed-in matrix where obvious
    typedef struct {
        logic [47:0] angles;
        logic        order;
        bit          typed;
        t_matrix     matrix;
    } t_vector;

    localparam t_matrix IDENTITY = {16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384,
                                    16'd0, 16'd0, 16'd0, 16'sd16384};

    t_vector vectors [$];

    initial begin
        vectors.push_back('{48'h0, ORDER_XYZ, 1, IDENTITY});
        vectors.push_back('{{16'hffff, 16'hffff, 16'hffff}, ORDER_XYZ, 0, '0});
        vectors.push_back('{{16'h0000, 16'h0000, 16'h4000}, ORDER_XYZ, 0, '0});
        vectors.push_back('{{16'h0000, 16'h4000, 16'h0000}, ORDER_XYZ, 0, '0});
        vectors.push_back('{{16'h4000, 16'h0000, 16'h0000}, ORDER_XYZ, 0, '0});
        vectors.push_back('{{16'h8000, 16'h8000, 16'h8000}, ORDER_XYZ, 0, '0});
        vectors.push_back('{{16'hc000, 16'h2000, 16'h6000}, ORDER_XYZ, 0, '0});
        vectors.push_back('{{16'h5555, 16'haaaa, 16'h0001}, ORDER_XYZ, 0, '0});
        vectors.push_back('{48'h0, ORDER_ZXY, 1, IDENTITY});
        vectors.push_back('{{16'hffff, 16'hffff, 16'hffff}, ORDER_ZXY, 0, '0});
        vectors.push_back('{{16'h4000, 16'h4000, 16'h4000}, ORDER_ZXY, 0, '0});
        vectors.push_back('{{16'h3fff, 16'hbfff, 16'h7fff}, ORDER_ZXY, 0, '0});
        vectors.push_back('{{16'haaaa, 16'h5555, 16'hfffe}, ORDER_ZXY, 0, '0});
    end

    // master side: random stalls and compare with the oldest pending matrix
    initial begin
        int      stall;
        t_matrix want;
        m_axis_tready = 1'b0;
        stall         = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_matrices.size() == 0) begin
                    $error("matrix with nothing expected: %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = pending_matrices.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (want[k*16 +: 16] !== m_axis_tdata[k*16 +: 16]) begin
                            $error("m%0d%0d expected %0d actual %0d", k / 3, k % 3,
                                   $signed(want[k*16 +: 16]),
                                   $signed(m_axis_tdata[k*16 +: 16]));
                            fail_count++;
                        end
                end
            end
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // one angle triple, held until the transaction completes; valid stays up
    // afterwards so the next triple can follow with no gap
    task automatic send_angles(input logic [47:0] angles, input bit gaps);
        if (gaps && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= angles;
        @(posedge i_clk iff s_axis_tready);
        pending_matrices.push_back(rotation_of(angles, model_order));
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        wait (pending_matrices.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_order(input logic order);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= order;
        @(posedge i_clk iff o_cfg_ready);
        model_order = order;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] random_angle;
        case ($urandom_range(0, 5))
            0: return {2'($urandom_range(0, 3)), 14'd0};
            1: return {2'($urandom_range(0, 3)), 14'h3fff};
            2: return 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_vector v;
        fail_count    = 0;
        model_order   = ORDER_XYZ;
        sink_idle_on  = 1'b1;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; the first row relies on the reset convention
        foreach (vectors[n]) begin
            v = vectors[n];
            if (n > 0 && v.order != model_order) begin
                drain();
                write_order(v.order);
            end
            send_angles(v.angles, 1);
            if (v.typed && rotation_of(v.angles, model_order) !== v.matrix) begin
                $error("model row %0d expected %h actual %h", n, v.matrix,
                       rotation_of(v.angles, model_order));
                fail_count++;
            end
        end

        // random phases, alternating between the two conventions
        for (int phase = 0; phase < 4; phase++) begin
            drain();
            write_order(phase[0] ? ORDER_XYZ : ORDER_ZXY);
            if (phase == 3) sink_idle_on = 1'b0;
            for (int n = 0; n < 100; n++) begin
                // hold off once until everything so far has come back
                if (phase == 1 && n == 50) drain();
                send_angles({random_angle(), random_angle(), random_angle()}, phase != 3);
            end
        end

        drain();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
src/eam_pkg.sv
src/eam_trig.sv
src/eam_mix.sv
src/euler_angles_to_rotation_matrix.sv
dv/euler_angles_to_rotation_matrix_tb.sv
